### rtl/sha1be_pkg.sv
// ----------------------------------------------------------------------------
// sha1be_pkg
// Shared types, register map codes and SHA-1 constants for the block engine.
// ----------------------------------------------------------------------------
package sha1be_pkg;

  // Bus access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Word address map
  localparam logic [4:0] ADDR_CONFIG = 5'd0;
  localparam logic [4:0] ADDR_RESET  = 5'd1;
  localparam logic [4:0] ADDR_RESULT = 5'd8;
  localparam logic [4:0] ADDR_RES_LAST = 5'd12;
  localparam logic [4:0] ADDR_DATA   = 5'd16;

  // Register bit positions
  localparam int CFG_START_BIT = 1;
  localparam int CFG_CONT_BIT  = 3;
  localparam int RST_BIT       = 0;

  // Storage geometry
  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int DIGEST_WORDS = 5;
  localparam int NUM_ROUNDS  = 80;

  // Standard initial hash value
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // Round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic        func;
    logic [4:0]  word_addr;
    logic [31:0] wdata;
  } sha1be_in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        busy_res;
  } sha1be_out_t;

  // Working variables of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1be_abcde_t;

  // Byte order swap between bus words and SHA-1 words
  function automatic logic [31:0] sha1be_swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

### rtl/sha1be_ram.sv
// ----------------------------------------------------------------------------
// sha1be_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha1be_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sha1be_round.sv
// ----------------------------------------------------------------------------
// sha1be_round
// One SHA-1 round: selects f and K by round index and updates a..e.
// ----------------------------------------------------------------------------
module sha1be_round
  import sha1be_pkg::*;
(
  input  sha1be_abcde_t cur,
  input  logic [31:0]   w,
  input  logic [6:0]    idx,
  output sha1be_abcde_t nxt
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;

  // Round function and constant per group of twenty rounds
  always_comb begin
    if (idx < 7'd20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K0;
    end else if (idx < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K1;
    end else if (idx < 7'd60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K3;
    end
  end

  assign t = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;

  // Shift the working variables
  assign nxt.a = t;
  assign nxt.b = cur.a;
  assign nxt.c = {cur.b[1:0], cur.b[31:2]};
  assign nxt.d = cur.c;
  assign nxt.e = cur.d;

endmodule

### rtl/sha1_block_engine_registers_core.sv
// ----------------------------------------------------------------------------
// sha1_block_engine_registers_core
// SHA-1 block engine behind a word register interface.
// ----------------------------------------------------------------------------
// Register and digest accesses return their result from the output register;
// data-in reads also pass the registered RAM read. A start write loads the
// block into the schedule window, runs the 80 rounds and adds to the digest.
// Results cannot be stalled. Data-in reads and start writes hold busy high
// until the result strobe, when a new transfer can be taken; others keep it low.
// Synchronous active-low reset clears digest, mode bit and sequencer, not the RAM.
module sha1_block_engine_registers_core
  import sha1be_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  sha1be_in_t  in_data,
  output logic        out_valid,
  output sha1be_out_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL
  } state_t;

  state_t        state_r, state_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          cont_r, cont_nxt;
  logic          out_valid_r, out_valid_nxt;
  sha1be_out_t   out_data_r, out_data_nxt;
  logic [31:0]   digest_r [DIGEST_WORDS];
  logic [31:0]   digest_nxt [DIGEST_WORDS];
  sha1be_abcde_t vars_r, vars_nxt;
  logic [31:0]   win_r [BLOCK_WORDS];
  logic [31:0]   win_nxt [BLOCK_WORDS];

  logic          accept;
  logic          ram_we;
  logic [3:0]    ram_raddr;
  logic [31:0]   ram_q;
  sha1be_abcde_t round_out;
  logic [31:0]   w_new;
  logic [31:0]   w_mix;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Data-in writes go straight to the block RAM
  assign ram_we    = accept && (in_data.func == FUNC_WRITE) && in_data.word_addr[4];
  assign ram_raddr = (state_r == ST_LOAD) ? cnt_r[3:0] : in_data.word_addr[3:0];

  sha1be_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BLOCK_WORDS)
  ) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.word_addr[3:0]),
    .wdata (in_data.wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Shared round unit, fed from the oldest schedule word
  sha1be_round u_round (
    .cur (vars_r),
    .w   (win_r[0]),
    .idx (cnt_r),
    .nxt (round_out)
  );

  // Message schedule expansion from fixed window taps
  assign w_mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cont_nxt      = cont_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    vars_nxt      = vars_r;
    digest_nxt    = digest_r;
    win_nxt       = win_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt.rdata    = '0;
          out_data_nxt.busy_res = 1'b0;
          if (in_data.func == FUNC_WRITE) begin
            if (in_data.word_addr == ADDR_CONFIG) begin
              cont_nxt = in_data.wdata[CFG_CONT_BIT];
              if (in_data.wdata[CFG_START_BIT]) begin
                state_nxt = ST_LOAD;
                cnt_nxt   = '0;
                if (!in_data.wdata[CFG_CONT_BIT]) begin
                  digest_nxt[0] = IV0;
                  digest_nxt[1] = IV1;
                  digest_nxt[2] = IV2;
                  digest_nxt[3] = IV3;
                  digest_nxt[4] = IV4;
                  vars_nxt = '{a: IV0, b: IV1, c: IV2, d: IV3, e: IV4};
                end else begin
                  vars_nxt = '{a: digest_r[0], b: digest_r[1], c: digest_r[2],
                               d: digest_r[3], e: digest_r[4]};
                end
              end else begin
                out_valid_nxt = 1'b1;
              end
            end else if (in_data.word_addr == ADDR_RESET) begin
              if (in_data.wdata[RST_BIT]) begin
                cont_nxt = 1'b0;
              end
              out_valid_nxt = 1'b1;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end else begin
            if (in_data.word_addr >= ADDR_DATA) begin
              state_nxt = ST_RD;
            end else begin
              out_valid_nxt = 1'b1;
              if (in_data.word_addr == ADDR_CONFIG) begin
                out_data_nxt.rdata[CFG_CONT_BIT] = cont_r;
              end else if (in_data.word_addr >= ADDR_RESULT &&
                           in_data.word_addr <= ADDR_RES_LAST) begin
                out_data_nxt.rdata = sha1be_swap32(digest_r[in_data.word_addr[2:0]]);
              end
            end
          end
        end
      end

      ST_RD: begin
        out_valid_nxt      = 1'b1;
        out_data_nxt.rdata = ram_q;
        state_nxt          = ST_IDLE;
      end

      // Stream the block into the window, one word per cycle
      ST_LOAD: begin
        if (cnt_r != 7'd0) begin
          for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            win_nxt[i] = win_r[i+1];
          end
          win_nxt[BLOCK_WORDS-1] = sha1be_swap32(ram_q);
        end
        if (cnt_r == 7'(BLOCK_WORDS)) begin
          state_nxt = ST_ROUND;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end

      // One round per cycle on the shared unit
      ST_ROUND: begin
        vars_nxt = round_out;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          win_nxt[i] = win_r[i+1];
        end
        win_nxt[BLOCK_WORDS-1] = w_new;
        if (cnt_r == 7'(NUM_ROUNDS - 1)) begin
          state_nxt = ST_FINAL;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end

      ST_FINAL: begin
        digest_nxt[0]      = digest_r[0] + vars_r.a;
        digest_nxt[1]      = digest_r[1] + vars_r.b;
        digest_nxt[2]      = digest_r[2] + vars_r.c;
        digest_nxt[3]      = digest_r[3] + vars_r.d;
        digest_nxt[4]      = digest_r[4] + vars_r.e;
        out_valid_nxt      = 1'b1;
        out_data_nxt.rdata = '0;
        state_nxt          = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    vars_r     <= vars_nxt;
    win_r      <= win_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cont_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        digest_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cont_r      <= cont_nxt;
      out_valid_r <= out_valid_nxt;
      digest_r    <= digest_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/sha1be_checker.sv
// ----------------------------------------------------------------------------
// sha1be_checker
// Port-level checks of the command handshake and result timing.
// ----------------------------------------------------------------------------
module sha1be_checker
  import sha1be_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input sha1be_in_t  in_data,
  input logic        out_valid,
  input sha1be_out_t out_data
);

  // Every transfer either goes busy or returns its result next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("transfer neither started work nor returned a result");

  // A compression start always holds the engine busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == FUNC_WRITE &&
     in_data.word_addr == ADDR_CONFIG && in_data.wdata[CFG_START_BIT]) |=> busy)
    else $error("compression start did not raise busy");

  // Results only appear while the engine is idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !out_data.busy_res))
    else $error("result strobed while busy");

  // Ending a long access always delivers its result
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("busy dropped without a result");

endmodule

bind sha1_block_engine_registers_core sha1be_checker u_sha1be_checker (.*);
